@@ hw/rtl/pcst_pkg.sv @@
// Shared widths, result codes and helper types for the point cone side test.
package pcst_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned AxisW  = 16;
    localparam int unsigned CosW   = 17;
    localparam int unsigned TolW   = 16;
    localparam int unsigned DiffW  = CoordW + 1;        // point - apex
    localparam int unsigned ProdW  = DiffW + AxisW;     // one dot term
    localparam int unsigned DotW   = ProdW + 2;         // sum of three terms
    localparam int unsigned PmW    = DotW - 1;          // |dot|
    localparam int unsigned SqW    = 2 * (DiffW - 1) + 2; // |d|^2 sum, 66 bits
    localparam int unsigned BoundW = CosW + 1;          // cos + tol
    localparam int unsigned Bound2W = 2 * BoundW;       // bound squared
    localparam int unsigned WideW  = 104;               // compare width
    localparam int unsigned PmHalf = 25;                // pm split point
    localparam int unsigned LenChunk = 22;              // len2 split chunk
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_APEX_X = 3'd0,
        REG_APEX_Y = 3'd1,
        REG_APEX_Z = 3'd2,
        REG_AXIS_X = 3'd3,
        REG_AXIS_Y = 3'd4,
        REG_AXIS_Z = 3'd5,
        REG_COS    = 3'd6,
        REG_TOL    = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SIDE_INSIDE  = 2'd0,
        SIDE_SURFACE = 2'd1,
        SIDE_OUTSIDE = 2'd2
    } t_side;

    // Bound squares handed to the square stage, refreshed from config each cycle.
    typedef struct packed {
        logic [Bound2W-1:0] upper2;
        logic [Bound2W-1:0] lower2;
        logic               lower_ok;
    } t_bounds;

endpackage

@@ hw/rtl/pcst_front.sv @@
// Stages 1-3: offset from apex, axis products and squares, dot and length sums.
module pcst_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [pcst_pkg::CoordW-1:0]     i_px,
    input  logic signed [pcst_pkg::CoordW-1:0]     i_py,
    input  logic signed [pcst_pkg::CoordW-1:0]     i_pz,
    input  logic signed [pcst_pkg::CoordW-1:0]     i_ax,
    input  logic signed [pcst_pkg::CoordW-1:0]     i_ay,
    input  logic signed [pcst_pkg::CoordW-1:0]     i_az,
    input  logic signed [pcst_pkg::AxisW-1:0]      i_nx,
    input  logic signed [pcst_pkg::AxisW-1:0]      i_ny,
    input  logic signed [pcst_pkg::AxisW-1:0]      i_nz,
    output logic                                   o_valid,
    output logic signed [pcst_pkg::DotW-1:0]       o_dot,
    output logic [pcst_pkg::SqW-1:0]               o_len2
);

    localparam int unsigned DW = pcst_pkg::DiffW;
    localparam int unsigned PW = pcst_pkg::ProdW;
    localparam int unsigned MW = DW - 1;

    logic                 r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    logic signed [PW-1:0] r_tx, r_ty, r_tz;
    logic [2*MW-1:0]      r_sx, r_sy, r_sz;
    logic signed [pcst_pkg::DotW-1:0] r_dot;
    logic [pcst_pkg::SqW-1:0]         r_len2;
    logic [MW-1:0]        ax_m, ay_m, az_m;

    // |d| is at most 2^32-1, so the magnitude fits 32 bits
    assign ax_m = MW'(r_dx[DW-1] ? -r_dx : r_dx);
    assign ay_m = MW'(r_dy[DW-1] ? -r_dy : r_dy);
    assign az_m = MW'(r_dz[DW-1] ? -r_dz : r_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_dx <= DW'($signed({i_px[pcst_pkg::CoordW-1], i_px})
                   - $signed({i_ax[pcst_pkg::CoordW-1], i_ax}));
        r_dy <= DW'($signed({i_py[pcst_pkg::CoordW-1], i_py})
                   - $signed({i_ay[pcst_pkg::CoordW-1], i_ay}));
        r_dz <= DW'($signed({i_pz[pcst_pkg::CoordW-1], i_pz})
                   - $signed({i_az[pcst_pkg::CoordW-1], i_az}));
        r_tx <= PW'(r_dx * i_nx);
        r_ty <= PW'(r_dy * i_ny);
        r_tz <= PW'(r_dz * i_nz);
        r_sx <= (2*MW)'(ax_m * ax_m);
        r_sy <= (2*MW)'(ay_m * ay_m);
        r_sz <= (2*MW)'(az_m * az_m);
        r_dot <= pcst_pkg::DotW'($signed({{2{r_tx[PW-1]}}, r_tx})
                 + $signed({{2{r_ty[PW-1]}}, r_ty})
                 + $signed({{2{r_tz[PW-1]}}, r_tz}));
        r_len2 <= pcst_pkg::SqW'({2'b00, r_sx} + {2'b00, r_sy} + {2'b00, r_sz});
    end

    assign o_valid = r_v3;
    assign o_dot   = r_dot;
    assign o_len2  = r_len2;

endmodule

@@ hw/rtl/pcst_square.sv @@
// Stages 4-5: 16*dot^2 and len2 times both bound squares via split partial products.
module pcst_square (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [pcst_pkg::DotW-1:0]    i_dot,
    input  logic [pcst_pkg::SqW-1:0]            i_len2,
    input  pcst_pkg::t_bounds                   i_bounds,
    output logic                                o_valid,
    output logic                                o_zero,
    output logic                                o_lower_ok,
    output logic [pcst_pkg::WideW-1:0]          o_lhs,
    output logic [pcst_pkg::WideW-1:0]          o_rup,
    output logic [pcst_pkg::WideW-1:0]          o_rlo
);

    localparam int unsigned H  = pcst_pkg::PmHalf;
    localparam int unsigned C  = pcst_pkg::LenChunk;
    localparam int unsigned B2 = pcst_pkg::Bound2W;
    localparam int unsigned W  = pcst_pkg::WideW;
    localparam int unsigned PM = 2 * H;

    logic [PM-1:0]   pm;
    logic            r_v4, r_v5;
    logic            r_zero4, r_zero5, r_lok4, r_lok5;
    logic [2*H-1:0]  r_hh, r_hl, r_ll;
    logic [C+B2-1:0] r_u0, r_u1, r_u2, r_l0, r_l1, r_l2;
    logic [W-1:0]    r_lhs, r_rup, r_rlo;
    logic [3*C-1:0]  len_ext;

    assign pm = i_dot[pcst_pkg::DotW-1] ? PM'(-i_dot) : PM'(i_dot);
    assign len_ext = (3*C)'(i_len2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
        end
        r_zero4 <= (i_len2 == '0);
        r_lok4  <= i_bounds.lower_ok;
        r_hh <= pm[PM-1:H] * pm[PM-1:H];
        r_hl <= pm[PM-1:H] * pm[H-1:0];
        r_ll <= pm[H-1:0] * pm[H-1:0];
        r_u0 <= len_ext[C-1:0]     * i_bounds.upper2;
        r_u1 <= len_ext[2*C-1:C]   * i_bounds.upper2;
        r_u2 <= len_ext[3*C-1:2*C] * i_bounds.upper2;
        r_l0 <= len_ext[C-1:0]     * i_bounds.lower2;
        r_l1 <= len_ext[2*C-1:C]   * i_bounds.lower2;
        r_l2 <= len_ext[3*C-1:2*C] * i_bounds.lower2;

        r_zero5 <= r_zero4;
        r_lok5  <= r_lok4;
        r_lhs <= ((W'(r_hh) << (2*H)) + (W'(r_hl) << (H+1)) + W'(r_ll)) << 4;
        r_rup <= W'(r_u0) + (W'(r_u1) << C) + (W'(r_u2) << (2*C));
        r_rlo <= W'(r_l0) + (W'(r_l1) << C) + (W'(r_l2) << (2*C));
    end

    assign o_valid    = r_v5;
    assign o_zero     = r_zero5;
    assign o_lower_ok = r_lok5;
    assign o_lhs      = r_lhs;
    assign o_rup      = r_rup;
    assign o_rlo      = r_rlo;

endmodule

@@ hw/rtl/pcst_cmp.sv @@
// Stage 6: exact compares against both bounds and the registered result.
module pcst_cmp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_zero,
    input  logic                        i_lower_ok,
    input  logic [pcst_pkg::WideW-1:0]  i_lhs,
    input  logic [pcst_pkg::WideW-1:0]  i_rup,
    input  logic [pcst_pkg::WideW-1:0]  i_rlo,
    output logic                        o_valid,
    output logic [1:0]                  o_side_code,
    output logic                        o_on_surface
);

    pcst_pkg::t_side n_side, r_side;
    logic            r_valid;

    always_comb begin
        n_side = pcst_pkg::SIDE_SURFACE;
        if (!i_zero) begin
            if (i_lhs > i_rup) begin
                n_side = pcst_pkg::SIDE_INSIDE;
            end else if (i_lower_ok && (i_lhs < i_rlo)) begin
                n_side = pcst_pkg::SIDE_OUTSIDE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side <= n_side;
    end

    assign o_valid      = r_valid;
    assign o_side_code  = r_side;
    assign o_on_surface = (r_side == pcst_pkg::SIDE_SURFACE);

endmodule

@@ hw/rtl/point_cone_side_test.sv @@
// Point against double cone classifier: config registers and six stage pipeline.
// Result path: a taken point passes front, square and compare registers to its strobe.
// Throughput: one point per cycle; busy is never raised, the six register stages hold it.
// Results leave on o_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears valid bits and sets config to its reset values.
module point_cone_side_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pcst_pkg::CoordW-1:0]  i_point_x,
    input  logic signed [pcst_pkg::CoordW-1:0]  i_point_y,
    input  logic signed [pcst_pkg::CoordW-1:0]  i_point_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pcst_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [pcst_pkg::CfgDataW-1:0]       i_cfg_data,
    output logic                                o_valid,
    output logic [1:0]                          o_side_code,
    output logic                                o_on_surface
);

    logic signed [pcst_pkg::CoordW-1:0] r_apex_x, r_apex_y, r_apex_z;
    logic signed [pcst_pkg::AxisW-1:0]  r_axis_x, r_axis_y, r_axis_z;
    logic [pcst_pkg::CosW-1:0]          r_cos;
    logic [pcst_pkg::TolW-1:0]          r_tol;
    pcst_pkg::t_bounds                  r_bounds;
    logic [pcst_pkg::BoundW-1:0]        upper, lower;

    logic                               f_valid;
    logic signed [pcst_pkg::DotW-1:0]   f_dot;
    logic [pcst_pkg::SqW-1:0]           f_len2;
    logic                               s_valid, s_zero, s_lok;
    logic [pcst_pkg::WideW-1:0]         s_lhs, s_rup, s_rlo;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apex_x <= '0;
            r_apex_y <= '0;
            r_apex_z <= '0;
            r_axis_x <= pcst_pkg::AxisW'(16384);
            r_axis_y <= '0;
            r_axis_z <= '0;
            r_cos    <= pcst_pkg::CosW'(65536);
            r_tol    <= pcst_pkg::TolW'(1);
        end else if (i_cfg_valid) begin
            case (pcst_pkg::t_cfg_reg'(i_cfg_index))
                pcst_pkg::REG_APEX_X: r_apex_x <= i_cfg_data;
                pcst_pkg::REG_APEX_Y: r_apex_y <= i_cfg_data;
                pcst_pkg::REG_APEX_Z: r_apex_z <= i_cfg_data;
                pcst_pkg::REG_AXIS_X: r_axis_x <= i_cfg_data[pcst_pkg::AxisW-1:0];
                pcst_pkg::REG_AXIS_Y: r_axis_y <= i_cfg_data[pcst_pkg::AxisW-1:0];
                pcst_pkg::REG_AXIS_Z: r_axis_z <= i_cfg_data[pcst_pkg::AxisW-1:0];
                pcst_pkg::REG_COS:    r_cos    <= i_cfg_data[pcst_pkg::CosW-1:0];
                pcst_pkg::REG_TOL:    r_tol    <= i_cfg_data[pcst_pkg::TolW-1:0];
                default: ;
            endcase
        end
    end

    // registered bound squares; the user must change config only while idle, not enforced
    assign upper = pcst_pkg::BoundW'(r_cos) + pcst_pkg::BoundW'(r_tol);
    assign lower = pcst_pkg::BoundW'(r_cos) - pcst_pkg::BoundW'(r_tol);

    always_ff @(posedge i_clk) begin
        r_bounds.upper2   <= upper * upper;
        r_bounds.lower2   <= lower * lower;
        r_bounds.lower_ok <= (r_cos > pcst_pkg::CosW'(r_tol));
    end

    pcst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_pz    (i_point_z),
        .i_ax    (r_apex_x),
        .i_ay    (r_apex_y),
        .i_az    (r_apex_z),
        .i_nx    (r_axis_x),
        .i_ny    (r_axis_y),
        .i_nz    (r_axis_z),
        .o_valid (f_valid),
        .o_dot   (f_dot),
        .o_len2  (f_len2)
    );

    pcst_square u_square (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .i_dot      (f_dot),
        .i_len2     (f_len2),
        .i_bounds   (r_bounds),
        .o_valid    (s_valid),
        .o_zero     (s_zero),
        .o_lower_ok (s_lok),
        .o_lhs      (s_lhs),
        .o_rup      (s_rup),
        .o_rlo      (s_rlo)
    );

    pcst_cmp u_cmp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_valid),
        .i_zero       (s_zero),
        .i_lower_ok   (s_lok),
        .i_lhs        (s_lhs),
        .i_rup        (s_rup),
        .i_rlo        (s_rlo),
        .o_valid      (o_valid),
        .o_side_code  (o_side_code),
        .o_on_surface (o_on_surface)
    );

endmodule

@@ dv/tb_point_cone_side_test.sv @@
// Testbench for the point against double cone classifier with a self-checking scoreboard.
module tb_point_cone_side_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        pcst_pkg::t_side side;
        logic            on_surf;
    } t_side_exp;

    class cone_scoreboard;
        logic signed [31:0] apex_x, apex_y, apex_z;
        logic signed [15:0] axis_x, axis_y, axis_z;
        logic [16:0]        cos_ha;
        logic [15:0]        tol;
        t_side_exp          side_q[$];
        int                 errors;

        function new();
            apex_x = 0; apex_y = 0; apex_z = 0;
            axis_x = 16384; axis_y = 0; axis_z = 0;
            cos_ha = 65536; tol = 1;
            errors = 0;
        endfunction

        function void set_reg(pcst_pkg::t_cfg_reg idx, logic [31:0] v);
            case (idx)
                pcst_pkg::REG_APEX_X: apex_x = v;
                pcst_pkg::REG_APEX_Y: apex_y = v;
                pcst_pkg::REG_APEX_Z: apex_z = v;
                pcst_pkg::REG_AXIS_X: axis_x = v[15:0];
                pcst_pkg::REG_AXIS_Y: axis_y = v[15:0];
                pcst_pkg::REG_AXIS_Z: axis_z = v[15:0];
                pcst_pkg::REG_COS:    cos_ha = v[16:0];
                pcst_pkg::REG_TOL:    tol = v[15:0];
                default: ;
            endcase
        endfunction

        function logic [159:0] abs_wide(longint v);
            return 160'(v < 0 ? -v : v);
        endfunction

        // classify d = point - apex against the cone, all compares exact on squares
        function void note_point(logic signed [31:0] px, py, pz);
            longint       dx, dy, dz, dot;
            logic [159:0] len2, lhs, up, lo, pm;
            t_side_exp    e;
            dx = longint'(px) - longint'(apex_x);
            dy = longint'(py) - longint'(apex_y);
            dz = longint'(pz) - longint'(apex_z);
            dot = dx * longint'(axis_x) + dy * longint'(axis_y) + dz * longint'(axis_z);
            len2 = abs_wide(dx) * abs_wide(dx) + abs_wide(dy) * abs_wide(dy)
                 + abs_wide(dz) * abs_wide(dz);
            e.side = pcst_pkg::SIDE_SURFACE;
            if (len2 != 0) begin
                pm = abs_wide(dot);
                lhs = (pm * pm) << 4;
                up = 160'(cos_ha) + 160'(tol);
                if (lhs > len2 * up * up) begin
                    e.side = pcst_pkg::SIDE_INSIDE;
                end else if (cos_ha > 17'(tol)) begin
                    lo = 160'(cos_ha) - 160'(tol);
                    if (lhs < len2 * lo * lo) e.side = pcst_pkg::SIDE_OUTSIDE;
                end
            end
            e.on_surf = (e.side == pcst_pkg::SIDE_SURFACE);
            side_q.push_back(e);
        endfunction

        function void check_side(logic [1:0] side, logic on_surf);
            t_side_exp e;
            if (side_q.size() == 0) begin
                $display("%0t: unexpected result side=%0d on_surface=%0b", $time, side, on_surf);
                errors++;
                return;
            end
            e = side_q.pop_front();
            if (side !== e.side) begin
                $display("%0t: side_code expected %0d actual %0d", $time, e.side, side);
                errors++;
            end
            if (on_surf !== e.on_surf) begin
                $display("%0t: on_surface expected %0b actual %0b", $time, e.on_surf, on_surf);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [pcst_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [pcst_pkg::CfgDataW-1:0] i_cfg_data = '0;
    logic        o_valid;
    logic [1:0]  o_side_code;
    logic        o_on_surface;

    cone_scoreboard sb = new();
    int idle_pct;

    always #6 i_clk = ~i_clk;

    point_cone_side_test u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_side_code(o_side_code), .o_on_surface(o_on_surface)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_side(o_side_code, o_on_surface);
    end

    task automatic write_reg(pcst_pkg::t_cfg_reg idx, logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    // one transaction; start stays high across back-to-back points
    task automatic send_point(logic [31:0] px, py, pz);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        do @(posedge i_clk); while (busy);
        sb.note_point(px, py, pz);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.side_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_cone(logic [31:0] ax, ay, az, logic [15:0] nx, ny, nz,
                            logic [16:0] c, logic [15:0] t);
        write_reg(pcst_pkg::REG_APEX_X, ax);
        write_reg(pcst_pkg::REG_APEX_Y, ay);
        write_reg(pcst_pkg::REG_APEX_Z, az);
        write_reg(pcst_pkg::REG_AXIS_X, 32'(signed'(nx)));
        write_reg(pcst_pkg::REG_AXIS_Y, 32'(signed'(ny)));
        write_reg(pcst_pkg::REG_AXIS_Z, 32'(signed'(nz)));
        write_reg(pcst_pkg::REG_COS, 32'(c));
        write_reg(pcst_pkg::REG_TOL, 32'(t));
    endtask

    function automatic logic [15:0] rand_axis();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // point near the cone: apex plus a multiple of the axis plus a perpendicular-ish offset
    task automatic send_near_cone();
        longint t, r, bx, by, bz;
        t = longint'($signed($urandom_range(65535))) - 32768;
        t = t <<< $urandom_range(4);
        r = longint'($signed($urandom_range(2047))) - 1024;
        r = r * t >>> $urandom_range(14, 8);
        bx = longint'(sb.apex_x) + ((t * longint'(sb.axis_x)) >>> 8) + r;
        by = longint'(sb.apex_y) + ((t * longint'(sb.axis_y)) >>> 8) - r;
        bz = longint'(sb.apex_z) + ((t * longint'(sb.axis_z)) >>> 8)
           + longint'($urandom_range(15)) - 8;
        send_point(bx[31:0], by[31:0], bz[31:0]);
    endtask

    task automatic send_directed();
        logic [31:0] a, b, c;
        a = sb.apex_x; b = sb.apex_y; c = sb.apex_z;
        send_point(a, b, c);                          // point at apex
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h7fffffff, 32'h80000000, 32'h0);
        send_point(a + 5, b, c);
        send_point(a - 7, b, c);
        send_point(a, b + 1, c);
        send_point(a, b, c - 3);
        send_point(a + 1, b + 1, c + 1);
    endtask

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        idle_pct = 17;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 10; p++) begin
            idle_pct = (p < 3) ? 17 : (p < 6) ? 87 : 0;
            case (p)
                0: ;  // reset configuration
                1: set_cone(0, 0, 0, 0, 0, 16384, 17'd0, 16'd0);
                2: set_cone(32'h7fffffff, 32'h80000000, 0, -16'sd16384, 0, 0,
                            17'd65536, 16'd65535);
                3: set_cone(32'h00010000, 32'hfffe0000, 32'h12345, 9459, 9459, 9459,
                            17'd46341, 16'd200);
                4: set_cone($urandom, $urandom, $urandom, 0, 0, 0, 17'd131071, 16'd0);
                default: set_cone($urandom, $urandom, $urandom,
                                  rand_axis(), rand_axis(), rand_axis(),
                                  17'($urandom_range(65536)),
                                  ($urandom_range(1) == 1) ? 16'($urandom_range(65535))
                                                           : 16'($urandom_range(600)));
            endcase
            if (p < 3) send_directed();
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(99) < 65) send_near_cone();
                else send_point($urandom, $urandom, $urandom);
            end
            drain();
        end
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
